### design/record_deque_core_assert.svh
// assertion macros for the record deque core
// used by modules that own a signal named clock and a signal named reset
`ifndef RECORD_DEQUE_CORE_ASSERT_SVH
`define RECORD_DEQUE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RDQ_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define RDQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rdq_pkg.sv
// shared types and codes for the record deque core
// no dependencies
package rdq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   // opcodes of a request beat
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_DUMP       = 3'd4;

   // status codes of a response beat
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [63:0]        id;
      logic [63:0]        name;
      logic [31:0]        gender;
      logic signed [31:0] score;
   } rec_type;

   // what a cell loads this cycle
   typedef enum logic [1:0] {
      MV_HOLD      = 2'd0,
      MV_LOAD      = 2'd1,
      MV_FROM_PREV = 2'd2,
      MV_FROM_NEXT = 2'd3
   } move_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

endpackage

### design/rdq_if.sv
// request and response channel interfaces of the record deque core
// depends on nothing but the field widths
interface rdq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         opcode;
   logic [63:0]        id_text;
   logic [63:0]        name_text;
   logic [31:0]        gender_text;
   logic signed [31:0] score;

   modport source (output valid, opcode, id_text, name_text, gender_text, score,
                   input ready);
   modport sink (input valid, opcode, id_text, name_text, gender_text, score,
                 output ready);
endinterface

interface rdq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [63:0]        out_id;
   logic [63:0]        out_name;
   logic [31:0]        out_gender;
   logic signed [31:0] out_score;
   logic               last;

   modport source (output valid, status, out_id, out_name, out_gender, out_score, last,
                   input ready);
   modport sink (input valid, status, out_id, out_name, out_gender, out_score, last,
                 output ready);
endinterface

### design/rdq_cell.sv
// one storage cell of the deque chain, holds a single record
// depends on rdq_pkg
module rdq_cell (
   input  logic              clock,
   input  rdq_pkg::move_type move,
   input  rdq_pkg::rec_type  push_rec,
   input  rdq_pkg::rec_type  prev_rec,
   input  rdq_pkg::rec_type  next_rec,
   output rdq_pkg::rec_type  rec
);
   import rdq_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;

   always_comb begin
      case (move)
         MV_HOLD:      rec_in = rec_ff;
         MV_LOAD:      rec_in = push_rec;
         MV_FROM_PREV: rec_in = prev_rec;
         MV_FROM_NEXT: rec_in = next_rec;
         default:      rec_in = rec_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

### design/record_deque_core.sv
// top level of the record deque core: cell chain, control and response register
// depends on rdq_pkg, rdq_if and rdq_cell, assertions from record_deque_core_assert.svh
`include "record_deque_core_assert.svh"

// Bounded double-ended queue of DEPTH records held in a row of cells, with the
// front entry always in cell 0 and the back entry in cell count-1. Push front
// shifts the row one cell back, push back loads cell count, pop front shifts the
// row one cell forward and pop back only lowers the count; each of these gives
// one response beat. A dump streams the entries front to back by rotating the
// occupied cells through cell 0, one beat a cycle while the consumer does not
// stall, and no request beat is taken until its last beat has been loaded.
// The response register lets a new request in while the previous response still
// waits, as long as the consumer takes it in the same cycle or the register is
// empty. No clearing pass after reset.
module record_deque_core #(
   parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   rdq_req_if.sink   req_bus,
   rdq_rsp_if.source rsp_bus
);
   import rdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   // control state
   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   left_ff, left_in;

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   rec_type         rsp_rec_ff, rsp_rec_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            req_fire;
   logic            out_free;
   logic            is_full;
   logic            is_empty;
   logic            push_f;
   logic            push_b;
   logic            pop_f;
   logic            pop_b;
   logic            dump_step;

   rec_type         push_rec;
   rec_type         cell_rec  [DEPTH];
   rec_type         next_rec  [DEPTH];
   rec_type         prev_rec  [DEPTH];
   move_type        cell_move [DEPTH];

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);

   // state changing operations, only when the store allows them
   assign push_f    = req_fire && (req_bus.opcode == OP_PUSH_FRONT) && !is_full;
   assign push_b    = req_fire && (req_bus.opcode == OP_PUSH_BACK) && !is_full;
   assign pop_f     = req_fire && (req_bus.opcode == OP_POP_FRONT) && !is_empty;
   assign pop_b     = req_fire && (req_bus.opcode == OP_POP_BACK) && !is_empty;
   assign dump_step = (state_ff == ST_DUMP) && out_free;

   assign push_rec.id     = req_bus.id_text;
   assign push_rec.name   = req_bus.name_text;
   assign push_rec.gender = req_bus.gender_text;
   assign push_rec.score  = req_bus.score;

   // the cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      // forward neighbour, wrapping from the back entry to cell 0 for the dump rotation
      if (i == DEPTH - 1) begin : g_wrap_end
         assign next_rec[i] = cell_rec[0];
      end else begin : g_wrap_mid
         assign next_rec[i] = (count_ff == CW'(i + 1)) ? cell_rec[0] : cell_rec[i + 1];
      end

      if (i == 0) begin : g_prev_head
         assign prev_rec[i] = push_rec;
      end else begin : g_prev_body
         assign prev_rec[i] = cell_rec[i - 1];
      end

      always_comb begin
         if (push_f) begin
            cell_move[i] = (i == 0) ? MV_LOAD : MV_FROM_PREV;
         end else if (push_b && (count_ff == CW'(i))) begin
            cell_move[i] = MV_LOAD;
         end else if (pop_f || dump_step) begin
            cell_move[i] = MV_FROM_NEXT;
         end else begin
            cell_move[i] = MV_HOLD;
         end
      end

      rdq_cell u_cell (
         .clock    (clock),
         .move     (cell_move[i]),
         .push_rec (push_rec),
         .prev_rec (prev_rec[i]),
         .next_rec (next_rec[i]),
         .rec      (cell_rec[i])
      );
   end

   // control and response beat
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_last_in   = rsp_last_ff;

      if (push_f || push_b) begin
         count_in = count_ff + 1'b1;
      end else if (pop_f || pop_b) begin
         count_in = count_ff - 1'b1;
      end

      if (req_fire) begin
         case (req_bus.opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = is_full ? STATUS_FULL : STATUS_DONE;
               rsp_rec_in    = '0;
               rsp_last_in   = 1'b1;
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = is_empty ? STATUS_EMPTY : STATUS_DONE;
               rsp_rec_in    = '0;
               rsp_last_in   = 1'b1;
            end
            OP_DUMP: begin
               if (is_empty) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
                  rsp_rec_in    = '0;
                  rsp_last_in   = 1'b1;
               end else begin
                  state_in = ST_DUMP;
                  left_in  = count_ff;
               end
            end
            default: begin
               // unused opcodes give no beat
            end
         endcase
      end

      // one entry a cycle from head cell when output is free, the row rotates behind it
      if (dump_step) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_DONE;
         rsp_rec_in    = cell_rec[0];
         rsp_last_in   = (left_ff == CW'(1));
         left_in       = left_ff - 1'b1;
         if (left_ff == CW'(1)) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.out_id     = rsp_rec_ff.id;
   assign rsp_bus.out_name   = rsp_rec_ff.name;
   assign rsp_bus.out_gender = rsp_rec_ff.gender;
   assign rsp_bus.out_score  = rsp_rec_ff.score;
   assign rsp_bus.last       = rsp_last_ff;

   // checks
   `RDQ_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CW'(DEPTH), "entry count above depth")
   `RDQ_ASSERT_SAME(a_dump_busy, state_ff == ST_DUMP,
      !req_bus.ready && !is_empty && (left_ff != '0) && (left_ff <= count_ff),
      "dump running on a bad count or taking requests")
   `RDQ_ASSERT_NEXT(a_dump_end, dump_step && (left_ff == CW'(1)),
      (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff,
      "final dump beat did not close the dump")

endmodule
